// ===== rtl/thp_pkg.sv =====
`default_nettype none

package thp_pkg;

    // Number of harmonic constituents and angle accumulator width (turns, 2^-48)
    localparam int unsigned ConN = 8;
    localparam int unsigned AngW = 48;
    localparam int unsigned SidxW = 6;
    localparam int unsigned SamplesDefault = 48;

    // Register indexes on the write port
    localparam logic [2:0] RegCoefM2K1 = 3'd0;
    localparam logic [2:0] RegCoefO1P1 = 3'd1;
    localparam logic [2:0] RegCoefN2Sa = 3'd2;
    localparam logic [2:0] RegCoefQ1K2 = 3'd3;
    localparam logic [2:0] RegDatum    = 3'd4;
    localparam logic [2:0] RegEpoch    = 3'd5;

    localparam logic [39:0] EpochReset = 40'd1735689600;

    // Constituent speeds in micro-degrees per hour (M2,K1,O1,P1,N2,SA,Q1,K2)
    localparam logic [63:0] SPEED_U [ConN] = '{
        64'd28984104, 64'd15041069, 64'd13943035, 64'd14958931,
        64'd28439730, 64'd41069,    64'd13398661, 64'd30082138
    };

    // Speeds converted to 2^-48 turns per second, rounded
    localparam logic [32:0] SPEED [ConN] = '{
        33'(((SPEED_U[0] << 35) + 64'd79101562) / 64'd158203125),
        33'(((SPEED_U[1] << 35) + 64'd79101562) / 64'd158203125),
        33'(((SPEED_U[2] << 35) + 64'd79101562) / 64'd158203125),
        33'(((SPEED_U[3] << 35) + 64'd79101562) / 64'd158203125),
        33'(((SPEED_U[4] << 35) + 64'd79101562) / 64'd158203125),
        33'(((SPEED_U[5] << 35) + 64'd79101562) / 64'd158203125),
        33'(((SPEED_U[6] << 35) + 64'd79101562) / 64'd158203125),
        33'(((SPEED_U[7] << 35) + 64'd79101562) / 64'd158203125)
    };

    // Quarter-wave cosine series constants (Q30)
    localparam logic [30:0] Q30One    = 31'h4000_0000;
    localparam logic [30:0] HalfPiQ30 = 31'd1686629713;

    // Series divisors as reciprocal multipliers: floor(p/d) = (p*M) >> SH for 32-bit p
    localparam int unsigned SER_SH [ConN] = '{40, 40, 40, 39, 38, 37, 36, 33};
    localparam logic [32:0] SER_M [ConN] = '{
        33'(((64'd1 << 40) + 64'd239) / 64'd240),
        33'(((64'd1 << 40) + 64'd181) / 64'd182),
        33'(((64'd1 << 40) + 64'd131) / 64'd132),
        33'(((64'd1 << 39) + 64'd89) / 64'd90),
        33'(((64'd1 << 38) + 64'd55) / 64'd56),
        33'(((64'd1 << 37) + 64'd29) / 64'd30),
        33'(((64'd1 << 36) + 64'd11) / 64'd12),
        33'(((64'd1 << 33) + 64'd1) / 64'd2)
    };

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [3:0][63:0] coef;
        logic [31:0]      datum;
        logic [39:0]      epoch;
    } cfg_t;

    // Side information travelling with each cosine request
    typedef struct packed {
        logic [15:0]      amp;
        logic [SidxW-1:0] sidx;
        logic             first;
        logic             last;
    } cos_tag_t;

    // One result item
    typedef struct packed {
        logic [SidxW-1:0]   sidx;
        logic signed [15:0] level;
        logic signed [15:0] height;
        logic               is_cur;
        logic               last;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/thp_front.sv =====
`default_nettype none

module thp_front
    import thp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [39:0]     s_tdata,
    input  logic [39:0]     epoch,
    input  logic            pop,
    output logic            q_valid,
    output logic [AngW-1:0] q_dt
);

    localparam int unsigned Depth = 2;

    logic [AngW-1:0] mem_reg [Depth];
    logic            wr_reg, rd_reg;
    logic [1:0]      cnt_reg;
    logic            push;
    logic [AngW-1:0] dt0;

    // Window start relative to the epoch, modulo one turn of the accumulator
    assign dt0 = {8'b0, s_tdata} - AngW'(43200) - {8'b0, epoch};

    assign s_tready = (cnt_reg != 2'(Depth));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_dt     = mem_reg[rd_reg];

    // Advance queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Hold request payload
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= dt0;
    end

endmodule

`default_nettype wire

// ===== rtl/thp_cos.sv =====
`default_nettype none

module thp_cos
    import thp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [15:0]        in_idx,
    input  cos_tag_t           in_tag,
    output logic               out_valid,
    output logic signed [17:0] out_cos,
    output cos_tag_t           out_tag
);

    typedef struct packed {
        cos_tag_t tag;
        logic     neg;
    } side_t;

    logic [1:0]  quad;
    logic [14:0] qq;
    logic [45:0] th_prod;
    logic [61:0] t2_prod;

    logic        v0_reg;
    logic [30:0] th_reg;
    side_t       s0_reg;

    // Series stages: index 0 is the squared angle, index k+1 follows term k
    logic [ConN-1:0] va_reg;
    logic [ConN:0]   vb_reg;
    logic [31:0]     ta_reg [ConN];
    logic [31:0]     pa_reg [ConN];
    side_t           sa_reg [ConN];
    logic [31:0]     tb_reg [ConN+1];
    logic [30:0]     rb_reg [ConN+1];
    side_t           sb_reg [ConN+1];

    logic [62:0] pprod [ConN];
    logic [64:0] dprod [ConN];
    logic [31:0] quot  [ConN];
    logic [30:0] rnew  [ConN];

    logic [16:0]        rr;
    logic               ov_reg;
    logic signed [17:0] oc_reg;
    cos_tag_t           ot_reg;

    // Fold the turn index onto the first quadrant
    assign quad    = in_idx[15:14];
    assign qq      = quad[0] ? (15'd16384 - {1'b0, in_idx[13:0]}) : {1'b0, in_idx[13:0]};
    assign th_prod = 46'(qq) * 46'(HalfPiQ30);
    assign t2_prod = 62'(th_reg) * 62'(th_reg);

    // One multiply per stage: product, then reciprocal divide and clamp
    always_comb
    begin
        for (int k = 0; k < ConN; k++)
        begin
            pprod[k] = 63'(tb_reg[k]) * 63'(rb_reg[k]);
            dprod[k] = 65'(pa_reg[k]) * 65'(SER_M[k]);
            quot[k]  = 32'(dprod[k] >> SER_SH[k]);
            rnew[k]  = (quot[k] >= 32'(Q30One)) ? 31'd0 : 31'(32'(Q30One) - quot[k]);
        end
    end

    // Round Q30 to Q16
    assign rr = 17'((33'(rb_reg[ConN]) + 33'd8192) >> 14);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            va_reg <= '0;
            vb_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            vb_reg[0] <= v0_reg;
            for (int k = 0; k < ConN; k++)
            begin
                va_reg[k]   <= vb_reg[k];
                vb_reg[k+1] <= va_reg[k];
            end
            ov_reg <= vb_reg[ConN];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_reg     <= th_prod[44:14];
            s0_reg.tag <= in_tag;
            s0_reg.neg <= quad[1] ^ quad[0];
            tb_reg[0]  <= t2_prod[61:30];
            rb_reg[0]  <= Q30One;
            sb_reg[0]  <= s0_reg;
            for (int k = 0; k < ConN; k++)
            begin
                ta_reg[k]   <= tb_reg[k];
                pa_reg[k]   <= pprod[k][61:30];
                sa_reg[k]   <= sb_reg[k];
                tb_reg[k+1] <= ta_reg[k];
                rb_reg[k+1] <= rnew[k];
                sb_reg[k+1] <= sa_reg[k];
            end
            oc_reg <= sb_reg[ConN].neg ? -$signed({1'b0, rr}) : $signed({1'b0, rr});
            ot_reg <= sb_reg[ConN].tag;
        end
    end

    assign out_valid = ov_reg;
    assign out_cos   = oc_reg;
    assign out_tag   = ot_reg;

endmodule

`default_nettype wire

// ===== rtl/thp_level.sv =====
`default_nettype none

module thp_level
    import thp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [36:0] in_hq,
    input  logic [SidxW-1:0]   in_sidx,
    input  logic [15:0]        half,
    output logic               out_valid,
    output logic [SidxW-1:0]   out_sidx,
    output logic signed [15:0] out_level,
    output logic signed [15:0] out_height
);

    localparam int unsigned QBits = 15;

    typedef struct packed {
        logic [SidxW-1:0]   sidx;
        logic signed [15:0] height;
        logic               neg;
        logic               sat;
        logic               zero;
    } side_t;

    logic signed [37:0] hq_w, hround, num;
    logic signed [21:0] hs;
    logic signed [15:0] hsat;
    logic [37:0]        mag, divd;
    logic [17:0]        den;
    side_t              s_in;

    logic [QBits:0]   v_reg;
    logic [37:0]      rem_reg [QBits+1];
    logic [QBits-1:0] q_reg   [QBits+1];
    side_t            sd_reg  [QBits+1];
    logic [37:0]      rem_nx  [QBits];
    logic [QBits-1:0] q_nx    [QBits];
    logic [37:0]      sub     [QBits];

    logic [QBits-1:0]   qm;
    logic               ov_reg;
    logic [SidxW-1:0]   os_reg;
    logic signed [15:0] ol_reg, oh_reg;

    // Height in mm, rounded and saturated
    assign hq_w   = {in_hq[36], in_hq};
    assign hround = hq_w + 38'sd32768;
    assign hs     = hround[37:16];
    assign hsat   = (hs > 22'sd32767) ? 16'sh7fff :
                    (hs < -22'sd32768) ? 16'sh8000 : hs[15:0];

    // Normalise against half level: dividend rounded to nearest, magnitude form
    assign den  = {half, 2'b00};
    assign num  = hq_w - $signed({6'b0, half, 16'b0});
    assign mag  = num[37] ? 38'(-num) : 38'(num);
    assign divd = mag + 38'({half, 1'b0});

    assign s_in.sidx   = in_sidx;
    assign s_in.height = hsat;
    assign s_in.neg    = num[37];
    assign s_in.sat    = (divd >= 38'({den, 15'b0}));
    assign s_in.zero   = (half == 16'd0);

    // One restoring step per stage, most significant quotient bit first
    always_comb
    begin
        for (int j = 0; j < QBits; j++)
        begin
            sub[j]    = 38'(den) << (QBits - 1 - j);
            rem_nx[j] = rem_reg[j];
            q_nx[j]   = q_reg[j];
            if (rem_reg[j] >= sub[j])
            begin
                rem_nx[j]              = rem_reg[j] - sub[j];
                q_nx[j][QBits - 1 - j] = 1'b1;
            end
        end
    end

    // Clamp quotient to one
    assign qm = (sd_reg[QBits].sat || q_reg[QBits] > 15'd16384) ? 15'd16384 : q_reg[QBits];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int j = 0; j < QBits; j++)
                v_reg[j+1] <= v_reg[j];
            ov_reg <= v_reg[QBits];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= divd;
            q_reg[0]   <= '0;
            sd_reg[0]  <= s_in;
            for (int j = 0; j < QBits; j++)
            begin
                rem_reg[j+1] <= rem_nx[j];
                q_reg[j+1]   <= q_nx[j];
                sd_reg[j+1]  <= sd_reg[j];
            end
            os_reg <= sd_reg[QBits].sidx;
            oh_reg <= sd_reg[QBits].height;
            if (sd_reg[QBits].zero)
                ol_reg <= 16'sd0;
            else if (sd_reg[QBits].neg)
                ol_reg <= -$signed({1'b0, qm});
            else
                ol_reg <= $signed({1'b0, qm});
        end
    end

    assign out_valid  = ov_reg;
    assign out_sidx   = os_reg;
    assign out_level  = ol_reg;
    assign out_height = oh_reg;

endmodule

`default_nettype wire

// ===== rtl/thp_back.sv =====
`default_nettype none

module thp_back
    import thp_pkg::*;
#(
    parameter int unsigned SAMPLES = SamplesDefault
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            req_valid,
    input  logic [AngW-1:0] req_dt,
    output logic            req_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output out_t            m_item
);

    localparam int unsigned Step  = 86400 / (SAMPLES - 1);
    localparam int unsigned Depth = 4;
    localparam logic [AngW-1:0] DELTA [ConN] = '{
        AngW'(64'(SPEED[0]) * 64'(Step)), AngW'(64'(SPEED[1]) * 64'(Step)),
        AngW'(64'(SPEED[2]) * 64'(Step)), AngW'(64'(SPEED[3]) * 64'(Step)),
        AngW'(64'(SPEED[4]) * 64'(Step)), AngW'(64'(SPEED[5]) * 64'(Step)),
        AngW'(64'(SPEED[6]) * 64'(Step)), AngW'(64'(SPEED[7]) * 64'(Step))
    };
    localparam logic [SidxW-1:0] LastIdx = SidxW'(SAMPLES - 1);
    localparam logic [SidxW-1:0] CurIdx  = SidxW'(SAMPLES / 2);

    typedef enum logic [1:0] {S_IDLE, S_INIT, S_RUN} state_t;

    state_t           state_reg;
    logic [3:0]       icnt_reg;
    logic [AngW-1:0]  dt0_reg;
    logic [AngW-1:0]  acc_reg [ConN];
    logic [2:0]       con_reg;
    logic [SidxW-1:0] sidx_reg;

    logic             pv_reg;
    logic [2:0]       pn_reg;
    logic [AngW-1:0]  plo_reg;
    logic [23:0]      phi_reg;

    logic [56:0] mlo;
    logic [47:0] mhi;
    logic [31:0] pw, cw;
    logic        adv, issue;

    cos_tag_t           ctag;
    logic               cv;
    logic signed [17:0] cval;
    cos_tag_t           ctag_o;

    logic               prv_reg;
    logic signed [34:0] prod_reg;
    cos_tag_t           prt_reg;
    logic signed [34:0] prod_w;
    logic signed [36:0] hq_reg, hq_sum, base;
    logic               lv_reg;
    logic [SidxW-1:0]   ls_reg;

    logic               lo_v;
    logic [SidxW-1:0]   lo_sidx;
    logic signed [15:0] lo_level, lo_height;

    out_t       fifo_reg [Depth];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    function automatic logic [31:0] coef_word(input cfg_t c, input logic [2:0] n);
        return n[0] ? c.coef[n[2:1]][63:32] : c.coef[n[2:1]][31:0];
    endfunction

    // Constituent issue and the cosine, weighting and level stages hold while the output buffer is full
    assign adv   = (cnt_reg != 3'(Depth));
    assign issue = (state_reg == S_RUN) && adv;

    // Initial angle: speed times window start, split into two partial products, plus the phase
    assign pw  = coef_word(cfg, pn_reg);
    assign mlo = 57'(SPEED[icnt_reg[2:0]]) * 57'(dt0_reg[23:0]);
    assign mhi = 48'(SPEED[icnt_reg[2:0]][23:0]) * 48'(dt0_reg[47:24]);

    assign req_pop = (state_reg == S_IDLE) && req_valid;

    // Sequence: load window, seed accumulators, issue constituents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            icnt_reg  <= 4'd0;
            con_reg   <= 3'd0;
            sidx_reg  <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            pv_reg <= (state_reg == S_INIT) && (icnt_reg < 4'(ConN));
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_INIT;
                        icnt_reg  <= 4'd0;
                    end
                end
                S_INIT:
                begin
                    icnt_reg <= icnt_reg + 4'd1;
                    if (icnt_reg == 4'(ConN))
                    begin
                        state_reg <= S_RUN;
                        con_reg   <= 3'd0;
                        sidx_reg  <= '0;
                    end
                end
                S_RUN:
                begin
                    if (issue)
                    begin
                        con_reg <= con_reg + 3'd1;
                        if (con_reg == 3'(ConN - 1))
                        begin
                            sidx_reg <= sidx_reg + SidxW'(1);
                            if (sidx_reg == LastIdx)
                                state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Hold window start, partial products and phase accumulators
    always_ff @(posedge clk)
    begin
        if (req_pop)
            dt0_reg <= req_dt;
        pn_reg  <= icnt_reg[2:0];
        plo_reg <= mlo[47:0];
        phi_reg <= mhi[23:0];
        if (pv_reg)
            acc_reg[pn_reg] <= plo_reg + {phi_reg, 24'b0} + {pw[31:16], 32'b0};
        else if (issue)
            acc_reg[con_reg] <= acc_reg[con_reg] + DELTA[con_reg];
    end

    assign cw         = coef_word(cfg, con_reg);
    assign ctag.amp   = cw[15:0];
    assign ctag.sidx  = sidx_reg;
    assign ctag.first = (con_reg == 3'd0);
    assign ctag.last  = (con_reg == 3'(ConN - 1));

    thp_cos u_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (state_reg == S_RUN),
        .in_idx   (acc_reg[con_reg][47:32]),
        .in_tag   (ctag),
        .out_valid(cv),
        .out_cos  (cval),
        .out_tag  (ctag_o)
    );

    // Weight by amplitude, then sum into the height
    assign prod_w = $signed({1'b0, ctag_o.amp}) * cval;
    assign base   = $signed(37'({cfg.datum[15:0], 16'b0}));
    assign hq_sum = (prt_reg.first ? base : hq_reg) + 37'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prv_reg <= 1'b0;
            lv_reg  <= 1'b0;
        end
        else if (adv)
        begin
            prv_reg <= cv;
            lv_reg  <= prv_reg && prt_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_w;
            prt_reg  <= ctag_o;
            if (prv_reg)
                hq_reg <= hq_sum;
            ls_reg <= prt_reg.sidx;
        end
    end

    thp_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (lv_reg),
        .in_hq     (hq_reg),
        .in_sidx   (ls_reg),
        .half      (cfg.datum[31:16]),
        .out_valid (lo_v),
        .out_sidx  (lo_sidx),
        .out_level (lo_level),
        .out_height(lo_height)
    );

    // Output buffer
    assign push    = adv && lo_v;
    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 3'd0);
    assign m_item  = fifo_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 2'd1;
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 3'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg].sidx   <= lo_sidx;
            fifo_reg[wr_reg].level  <= lo_level;
            fifo_reg[wr_reg].height <= lo_height;
            fifo_reg[wr_reg].is_cur <= (lo_sidx == CurIdx);
            fifo_reg[wr_reg].last   <= (lo_sidx == LastIdx);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tide_harmonic_predictor.sv =====
`default_nettype none

// Channel  Signals                        Carries
// -------  -----------------------------  ------------------------------------------
// s        s_tvalid s_tready s_tdata      request: now_seconds
// m        m_tvalid m_tready m_tdata      sample_index, level, height_mm
//          m_tuser m_tlast                is_current, last sample of the window
// cfg      cfg_we cfg_index cfg_wdata     coefficient, datum and epoch registers
//
// Each request gives SAMPLES results. The back end first seeds the
// phase accumulators, then feeds one constituent per cycle into the shared
// cosine pipeline while the output buffer has room. The front queue holds
// two requests meanwhile.
// rst_n clears all control state and loads register reset values.
// A four-entry output buffer decouples m_tready; when it is full the back end holds.

module tide_harmonic_predictor
    import thp_pkg::*;
#(
    parameter int unsigned SAMPLES = SamplesDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [39:0] now_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] sample_index, [21:6] level, [37:22] height_mm
    output logic        m_tuser,   // [0] is_current
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    cfg_t            cfg_reg;
    logic            q_valid, q_pop;
    logic [AngW-1:0] q_dt;
    out_t            item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef  <= '0;
            cfg_reg.datum <= '0;
            cfg_reg.epoch <= EpochReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegCoefM2K1: cfg_reg.coef[0] <= cfg_wdata;
                RegCoefO1P1: cfg_reg.coef[1] <= cfg_wdata;
                RegCoefN2Sa: cfg_reg.coef[2] <= cfg_wdata;
                RegCoefQ1K2: cfg_reg.coef[3] <= cfg_wdata;
                RegDatum:    cfg_reg.datum   <= cfg_wdata[31:0];
                RegEpoch:    cfg_reg.epoch   <= cfg_wdata[39:0];
                default:     ;
            endcase
        end
    end

    thp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .epoch   (cfg_reg.epoch),
        .pop     (q_pop),
        .q_valid (q_valid),
        .q_dt    (q_dt)
    );

    thp_back #(
        .SAMPLES(SAMPLES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .req_valid(q_valid),
        .req_dt   (q_dt),
        .req_pop  (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_item   (item)
    );

    assign m_tdata = {2'b00, item.height, item.level, item.sidx};
    assign m_tuser = item.is_cur;
    assign m_tlast = item.last;

    // Window markers sit on the right samples
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[5:0] == 6'(SAMPLES - 1))
        else $error("last flag on wrong sample");

    a_cur_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[5:0] == 6'(SAMPLES / 2))
        else $error("current flag on wrong sample");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[21:6]) >= -16'sd16384) &&
                     ($signed(m_tdata[21:6]) <= 16'sd16384))
        else $error("level outside clamp range");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
    import thp_pkg::*;

    localparam int unsigned NSAMP = 48;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    // Expected samples for the tide windows and the register copy that produces them
    class tide_window_board;
        logic [63:0] coef [4];
        logic [31:0] datum;
        logic [39:0] epoch;
        out_t        pending_samples [$];
        int unsigned mismatches;
        int unsigned checked;
        logic [63:0] speed [8];

        function new();
            longint unsigned udeg [8] = '{28984104, 15041069, 13943035, 14958931,
                                           28439730, 41069, 13398661, 30082138};
            foreach (speed[n])
                speed[n] = ((64'(udeg[n]) << 35) + 64'd79101562) / 64'd158203125;
            foreach (coef[k])
                coef[k] = '0;
            datum = '0;
            epoch = EpochReset;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                RegCoefM2K1: coef[0] = val;
                RegCoefO1P1: coef[1] = val;
                RegCoefN2Sa: coef[2] = val;
                RegCoefQ1K2: coef[3] = val;
                RegDatum:    datum = val[31:0];
                RegEpoch:    epoch = val[39:0];
                default: ;
            endcase
        endfunction

        // Taylor series for one quarter wave, Q16 result
        function longint quarter_wave(longint q);
            longint divs [8] = '{240, 182, 132, 90, 56, 30, 12, 2};
            longint th, t2, r, p;
            th = longint'((64'(q) * 64'd1686629713) >> 14);
            t2 = (th * th) >>> 30;
            r = longint'(1) << 30;
            for (int k = 0; k < 8; k++)
            begin
                p = (t2 * r) >>> 30;
                r = (longint'(1) << 30) - p / divs[k];
                if (r < 0)
                    r = 0;
            end
            r = (r + 8192) >>> 14;
            if (r > 65536)
                r = 65536;
            return r;
        endfunction

        function longint turn_cosine(logic [15:0] idx);
            longint q;
            q = longint'(idx[13:0]);
            case (idx[15:14])
                2'd0: return quarter_wave(q);
                2'd1: return -quarter_wave(16384 - q);
                2'd2: return -quarter_wave(q);
                default: return quarter_wave(16384 - q);
            endcase
        endfunction

        // Work out the whole window of samples for one accepted request
        function void note_request(logic [39:0] now);
            longint dt, hq, hmm, lvl, num, den, mag, qm, half, amp;
            logic [31:0] w;
            logic [63:0] ang;
            out_t s;
            half = longint'(datum[31:16]);
            for (int i = 0; i < NSAMP; i++)
            begin
                dt = longint'({24'd0, now}) - 43200 + i * (86400 / (NSAMP - 1))
                     - longint'({24'd0, epoch});
                hq = longint'(datum[15:0]) * 65536;
                for (int n = 0; n < 8; n++)
                begin
                    w = n[0] ? coef[n >> 1][63:32] : coef[n >> 1][31:0];
                    amp = longint'(w[15:0]);
                    ang = speed[n] * 64'(dt) + ({48'd0, w[31:16]} << 32);
                    hq += amp * turn_cosine(ang[47:32]);
                end
                hmm = (hq + 32768) >>> 16;
                if (hmm > 32767)
                    hmm = 32767;
                if (hmm < -32768)
                    hmm = -32768;
                lvl = 0;
                if (half != 0)
                begin
                    num = hq - half * 65536;
                    den = 4 * half;
                    mag = num < 0 ? -num : num;
                    qm = (mag + den / 2) / den;
                    if (qm > 16384)
                        qm = 16384;
                    lvl = num < 0 ? -qm : qm;
                end
                s.sidx = i[5:0];
                s.level = lvl[15:0];
                s.height = hmm[15:0];
                s.is_cur = (i == NSAMP / 2);
                s.last = (i == NSAMP - 1);
                pending_samples.push_back(s);
            end
        endfunction

        // Compare one delivered sample with the oldest expectation
        function void check_sample(logic [39:0] data, logic user, logic tl);
            out_t e;
            checked++;
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected sample data=%h user=%b last=%b",
                         $realtime, data, user, tl);
                mismatches++;
                return;
            end
            e = pending_samples.pop_front();
            if (data[5:0] !== e.sidx)
            begin
                $display("%0t: sample_index expected %0d got %0d", $realtime, e.sidx, data[5:0]);
                mismatches++;
            end
            if (data[21:6] !== e.level)
            begin
                $display("%0t: level (sample %0d) expected %0d got %0d", $realtime, e.sidx,
                         e.level, $signed(data[21:6]));
                mismatches++;
            end
            if (data[37:22] !== e.height)
            begin
                $display("%0t: height_mm (sample %0d) expected %0d got %0d", $realtime, e.sidx,
                         e.height, $signed(data[37:22]));
                mismatches++;
            end
            if (data[39:38] !== 2'b00)
            begin
                $display("%0t: pad bits expected 0 got %b", $realtime, data[39:38]);
                mismatches++;
            end
            if (user !== e.is_cur)
            begin
                $display("%0t: is_current expected %b got %b", $realtime, e.is_cur, user);
                mismatches++;
            end
            if (tl !== e.last)
            begin
                $display("%0t: last expected %b got %b", $realtime, e.last, tl);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;

    tide_window_board board;
    int unsigned cycles;
    int unsigned requests_sent;
    int unsigned settings_used;
    int unsigned sink_wait;
    bit          calm;

    tide_harmonic_predictor #(.SAMPLES(NSAMP)) uut (.*);

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
    end

    always #5 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    // Sink: stall a random number of cycles after each sample, none while calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end
        else if (sink_wait > 0)
        begin
            m_tready <= 1'b0;
            sink_wait <= sink_wait - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (m_tvalid && m_tready)
                sink_wait <= calm ? 0 : $urandom_range(0, 13);
        end
    end

    // Check every sample taken by the sink
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_sample(m_tdata, m_tuser, m_tlast);
    end

    // Offer one request after a random gap (none while calm) and hold it until taken
    task automatic send_request(logic [39:0] now);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= now;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(now);
        requests_sent++;
    endtask

    // Hold the sender until every sample is back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_samples.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write one register, then leave the write port idle before returning
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Coefficient pair with amplitudes up to a chosen size
    function automatic logic [63:0] rand_coef(int unsigned amp_max);
        return {16'($urandom), 16'($urandom_range(0, amp_max)),
                16'($urandom), 16'($urandom_range(0, amp_max))};
    endfunction

    // Times near the epoch, with some anywhere in the range
    function automatic logic [39:0] rand_time();
        logic [39:0] t;
        if ($urandom_range(0, 3) == 0)
            t = {$urandom, $urandom};
        else
            t = board.epoch + 40'($signed(32'($urandom)) >>> $urandom_range(0, 8));
        return t;
    endfunction

    initial
    begin
        board = new();
        cycles = 0;
        requests_sent = 0;
        settings_used = 1;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: all coefficients zero
        send_request(40'd0);
        send_request({40{1'b1}});
        send_request(EpochReset);
        drain();

        // All register bits set, epoch at zero
        for (int k = 0; k < 4; k++)
            write_reg(3'(k), {64{1'b1}});
        write_reg(RegDatum, {64{1'b1}});
        write_reg(RegEpoch, 64'd0);
        settings_used++;
        calm = 1'b1;
        send_request(40'd0);
        send_request(40'd43199);
        send_request(40'd43200);
        send_request({40{1'b1}});
        calm = 1'b0;
        send_request(rand_time());
        drain();

        // Full amplitudes in phase with a zero datum word; top epoch
        for (int k = 0; k < 4; k++)
            write_reg(3'(k), 64'h0000_FFFF_0000_FFFF);
        write_reg(RegDatum, 64'h0000_0001_0000_0000);
        write_reg(RegEpoch, {64{1'b1}});
        write_reg(3'd6, rand64());
        write_reg(3'd7, rand64());
        settings_used++;
        send_request({40{1'b1}});
        send_request(40'd0);
        send_request({40{1'b1}} - 40'd43200);
        send_request(rand_time());
        drain();

        // Zero half level with a non-zero mean
        write_reg(RegDatum, 64'h0000_0000_0000_8000);
        write_reg(RegEpoch, 64'd1000);
        settings_used++;
        send_request(40'd0);
        send_request(40'd1000);
        send_request(rand_time());
        drain();

        // Random stations
        for (int ph = 0; ph < 6; ph++)
        begin
            int unsigned amp_max;
            amp_max = (ph % 3 == 0) ? 65535 : 3000;
            for (int k = 0; k < 4; k++)
                write_reg(3'(k), rand_coef(amp_max));
            write_reg(RegDatum, {rand64()} & (ph == 5 ? 64'hFFFF_FFFF_FFFF_FFFF :
                                 64'hFFFF_FFFF_3FFF_3FFF));
            write_reg(RegEpoch, ph == 4 ? rand64() : {24'd0, 40'd1735689600 +
                                  40'($urandom_range(0, 400000000))});
            settings_used++;
            for (int j = 0; j < 26; j++)
            begin
                calm = (j >= 8 && j < 14);
                if (j == 18)
                    drain();
                send_request(rand_time());
            end
            calm = 1'b0;
            drain();
        end

        repeat (100) @(posedge clk);
        $display("covered %0d windows under %0d register settings, %0d samples checked",
                 requests_sent, settings_used, board.checked);
        $display("extremes of time and epoch, saturated heights, clamped and zero levels");
        if (board.mismatches == 0 && board.pending_samples.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/thp_pkg.sv
rtl/thp_front.sv
rtl/thp_cos.sv
rtl/thp_level.sv
rtl/thp_back.sv
rtl/tide_harmonic_predictor.sv
tb/sv/tb.sv
